/* hdl/coo_spmv_pkg.sv */
package coo_spmv_pkg;

  localparam int unsigned ROW_W = 16;
  localparam int unsigned COL_W = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ACC_W = 40;
  localparam int unsigned FRAC_W = 30;
  localparam int unsigned PROD_W = 2 * VAL_W;
  // Rounded product: Q4.60 shifted down to Q.30 keeps PROD_W - FRAC_W bits.
  localparam int unsigned RND_W = PROD_W - FRAC_W;
  localparam int unsigned DEFAULT_VECTOR_DEPTH = 65536;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_NONZERO = 2'd1;
  localparam logic [1:0] CMD_FLUSH   = 2'd2;

  // Control that travels alongside an item through the pipeline.
  typedef struct packed {
    logic             nonzero;
    logic             flush;
    logic [ROW_W-1:0] row;
  } stage_ctrl_t;

  typedef struct packed {
    logic [ROW_W-1:0]        out_row;
    logic signed [ACC_W-1:0] row_sum;
    logic                    row_valid;
    logic                    last;
  } result_t;

endpackage

/* hdl/coo_spmv_vec_mem.sv */
// Dense vector store: loads write at acceptance, nonzero items read the
// element of their column through a registered read.
module coo_spmv_vec_mem #(
  parameter int unsigned VECTOR_DEPTH = coo_spmv_pkg::DEFAULT_VECTOR_DEPTH
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     advance,
  input  logic                                     accept,
  input  logic [1:0]                               command,
  input  logic [coo_spmv_pkg::COL_W-1:0]           column_index,
  input  logic [coo_spmv_pkg::ROW_W-1:0]           row_index,
  input  logic signed [coo_spmv_pkg::VAL_W-1:0]    value,
  output coo_spmv_pkg::stage_ctrl_t                s1_ctrl,
  output logic signed [coo_spmv_pkg::VAL_W-1:0]    s1_value,
  output logic signed [coo_spmv_pkg::VAL_W-1:0]    s1_elem
);

  localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  logic [coo_spmv_pkg::VAL_W-1:0] mem [VECTOR_DEPTH];
  logic [coo_spmv_pkg::VAL_W-1:0] rdata;
  logic [AW-1:0]                  addr;
  logic                           in_range;
  logic                           s1_in_range;

  assign addr     = AW'(column_index);
  assign in_range = 32'(column_index) < 32'(VECTOR_DEPTH);

  always_ff @(posedge clk) begin
    if (accept && command == coo_spmv_pkg::CMD_LOAD && in_range) begin
      mem[addr] <= value;
    end
    if (advance) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl.nonzero <= 1'b0;
      s1_ctrl.flush   <= 1'b0;
    end else if (advance) begin
      s1_ctrl.nonzero <= accept && command == coo_spmv_pkg::CMD_NONZERO;
      s1_ctrl.flush   <= accept && command == coo_spmv_pkg::CMD_FLUSH;
      s1_ctrl.row     <= row_index;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_value    <= value;
      s1_in_range <= in_range;
    end
  end

  // A column beyond the store multiplies by zero.
  assign s1_elem = s1_in_range ? $signed(rdata) : '0;

endmodule

/* hdl/coo_spmv_mac.sv */
// Multiply, round to Q.30 and accumulate per row with saturation.
module coo_spmv_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  input  coo_spmv_pkg::stage_ctrl_t             s1_ctrl,
  input  logic signed [coo_spmv_pkg::VAL_W-1:0] s1_value,
  input  logic signed [coo_spmv_pkg::VAL_W-1:0] s1_elem,
  output logic                                  emit,
  output coo_spmv_pkg::result_t                 res
);

  localparam int unsigned SUM_W = coo_spmv_pkg::ACC_W + 2;

  coo_spmv_pkg::stage_ctrl_t s2_ctrl;
  coo_spmv_pkg::stage_ctrl_t s3_ctrl;

  logic signed [coo_spmv_pkg::PROD_W-1:0] prod_next;
  logic signed [coo_spmv_pkg::PROD_W-1:0] product;
  logic signed [coo_spmv_pkg::RND_W-1:0]  rounded_next;
  logic signed [coo_spmv_pkg::RND_W-1:0]  rounded;

  logic [coo_spmv_pkg::ROW_W-1:0]        open_row;
  logic                                  row_is_open;
  logic signed [coo_spmv_pkg::ACC_W-1:0] acc;

  logic                                  same_row;
  logic signed [coo_spmv_pkg::ACC_W-1:0] acc_base;
  logic signed [SUM_W-1:0]               sum;
  logic signed [coo_spmv_pkg::ACC_W-1:0] acc_next;

  assign prod_next = s1_value * s1_elem;

  // Round half up: add the bit just below the cut.
  assign rounded_next = coo_spmv_pkg::RND_W'(product >>> coo_spmv_pkg::FRAC_W)
                      + coo_spmv_pkg::RND_W'(product[coo_spmv_pkg::FRAC_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctrl.nonzero <= 1'b0;
      s2_ctrl.flush   <= 1'b0;
      s3_ctrl.nonzero <= 1'b0;
      s3_ctrl.flush   <= 1'b0;
    end else if (advance) begin
      s2_ctrl.nonzero <= s1_ctrl.nonzero;
      s2_ctrl.flush   <= s1_ctrl.flush;
      s2_ctrl.row     <= s1_ctrl.row;
      s3_ctrl.nonzero <= s2_ctrl.nonzero;
      s3_ctrl.flush   <= s2_ctrl.flush;
      s3_ctrl.row     <= s2_ctrl.row;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      product     <= prod_next;
      rounded     <= rounded_next;
    end
  end

  assign same_row = row_is_open && s3_ctrl.row == open_row;
  assign acc_base = same_row ? acc : '0;
  assign sum      = SUM_W'(acc_base) + SUM_W'(rounded);

  // Clamp whenever the top bits disagree with the accumulator's sign bit.
  always_comb begin
    if (sum[SUM_W-1:coo_spmv_pkg::ACC_W-1] == '0 ||
        sum[SUM_W-1:coo_spmv_pkg::ACC_W-1] == '1) begin
      acc_next = sum[coo_spmv_pkg::ACC_W-1:0];
    end else if (sum[SUM_W-1]) begin
      acc_next = {1'b1, {(coo_spmv_pkg::ACC_W-1){1'b0}}};
    end else begin
      acc_next = {1'b0, {(coo_spmv_pkg::ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_row    <= '0;
      row_is_open <= 1'b0;
      acc         <= '0;
    end else if (advance) begin
      if (s3_ctrl.nonzero) begin
        open_row    <= s3_ctrl.row;
        row_is_open <= 1'b1;
        acc         <= acc_next;
      end else if (s3_ctrl.flush) begin
        open_row    <= '0;
        row_is_open <= 1'b0;
        acc         <= '0;
      end
    end
  end

  always_comb begin
    emit          = s3_ctrl.flush || (s3_ctrl.nonzero && row_is_open && !same_row);
    res.out_row   = row_is_open ? open_row : '0;
    res.row_sum   = row_is_open ? acc : '0;
    res.row_valid = row_is_open;
    res.last      = s3_ctrl.flush;
  end

endmodule

/* hdl/coo_sparse_matrix_vector_multiply_top.sv */
// Sparse COO matrix times dense vector. Send load items (command 0) to fill
// the vector store with signed Q2.30 elements, then nonzero items (command 1)
// sorted by row, then one flush item (command 2). A row's saturated Q10.30
// sum comes out when the next nonzero names another row, and the flush gives
// the open row marked last (or an empty result with row_valid low). The block
// takes one item per clock cycle while the result side is not stalling; a
// result's path from its accepted item runs through the registered read of
// the vector memory, the register after the 32 by 32 bit multiplier and the
// rounding register, after which the output register is loaded on the same
// edge as the accumulator. Load items
// write the memory in the cycle they are accepted, so a nonzero item may
// follow its element's load immediately. The vector store is not cleared by
// reset: every element must be loaded before a nonzero item reads it.
module coo_sparse_matrix_vector_multiply_top #(
  parameter int unsigned VECTOR_DEPTH = coo_spmv_pkg::DEFAULT_VECTOR_DEPTH
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cmd_valid,
  output logic                                     cmd_stall,
  input  logic [1:0]                               command,
  input  logic [coo_spmv_pkg::COL_W-1:0]           column_index,
  input  logic [coo_spmv_pkg::ROW_W-1:0]           row_index,
  input  logic signed [coo_spmv_pkg::VAL_W-1:0]    value,
  output logic                                     res_valid,
  input  logic                                     res_stall,
  output logic [coo_spmv_pkg::ROW_W-1:0]           out_row,
  output logic signed [coo_spmv_pkg::ACC_W-1:0]    row_sum,
  output logic                                     row_valid,
  output logic                                     last
);

  coo_spmv_pkg::stage_ctrl_t                 s1_ctrl;
  logic signed [coo_spmv_pkg::VAL_W-1:0]     s1_value;
  logic signed [coo_spmv_pkg::VAL_W-1:0]     s1_elem;
  logic                                      emit;
  coo_spmv_pkg::result_t                     res;
  logic                                      advance;
  logic                                      accept;

  // The whole pipeline moves together; it only holds while a finished result
  // sits in the output register and the receiver stalls it.
  assign advance   = !(res_valid && res_stall);
  assign cmd_stall = !advance;
  assign accept    = cmd_valid && advance;

  coo_spmv_vec_mem #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_vec_mem (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .accept       (accept),
    .command      (command),
    .column_index (column_index),
    .row_index    (row_index),
    .value        (value),
    .s1_ctrl      (s1_ctrl),
    .s1_value     (s1_value),
    .s1_elem      (s1_elem)
  );

  coo_spmv_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .s1_ctrl  (s1_ctrl),
    .s1_value (s1_value),
    .s1_elem  (s1_elem),
    .emit     (emit),
    .res      (res)
  );

  // Output register: valid is reloaded on every advance and the fields on every
  // emitted result, so a taken item is replaced in the same cycle and the rate stays at one item per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_row   <= res.out_row;
      row_sum   <= res.row_sum;
      row_valid <= res.row_valid;
      last      <= res.last;
    end
  end

endmodule
